[src/iir_df1_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the direct-form-I iir filter
package iir_df1_pkg;

    localparam int COEF_WIDTH = 18;
    localparam int COEF_FRAC  = 14;

    localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = 18'sd16384;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MAC   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_LO    = 6'b001000,
        S_HI    = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic rotate;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
    } scale_ctl_t;

endpackage

[src/iir_df1_if.sv]
`timescale 1ns / 1ps
// sample channels of the iir filter: input beat and output beat
interface iir_df1_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_df1_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

[src/iir_df1_cell.sv]
`timescale 1ns / 1ps
// one ring cell: a coefficient and a history sample, passed to the neighbor
module iir_df1_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter logic signed [iir_df1_pkg::COEF_WIDTH-1:0] COEF_RESET = '0
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  iir_df1_pkg::cell_ctl_t                   ctl,
    input  logic signed [iir_df1_pkg::COEF_WIDTH-1:0] cfg_coef,
    input  logic signed [iir_df1_pkg::COEF_WIDTH-1:0] nb_coef,
    input  logic signed [SAMPLE_WIDTH-1:0]           nb_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]           new_sample,
    output logic signed [iir_df1_pkg::COEF_WIDTH-1:0] coef,
    output logic signed [SAMPLE_WIDTH-1:0]           sample
);
    import iir_df1_pkg::*;

    logic signed [COEF_WIDTH-1:0]   coef_reg;
    logic signed [COEF_WIDTH-1:0]   coef_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_next;

    always_comb
    begin
        coef_next   = coef_reg;
        sample_next = sample_reg;
        if (ctl.load)
        begin
            coef_next = cfg_coef;
        end
        if (ctl.rotate)
        begin
            coef_next   = nb_coef;
            sample_next = nb_sample;
        end
        else if (ctl.shift)
        begin
            sample_next = new_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg   <= COEF_RESET;
            sample_reg <= '0;
        end
        else
        begin
            coef_reg   <= coef_next;
            sample_reg <= sample_next;
        end
    end

    assign coef   = coef_reg;
    assign sample = sample_reg;

endmodule

[src/iir_df1_scale.sv]
`timescale 1ns / 1ps
// scaling by the leading reciprocal in two partial products, rounding and saturation
module iir_df1_scale #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 37
) (
    input  logic                                     clk,
    input  iir_df1_pkg::scale_ctl_t                  ctl,
    input  logic signed [ACC_WIDTH-1:0]              acc,
    input  logic signed [iir_df1_pkg::COEF_WIDTH-1:0] recip,
    output logic signed [SAMPLE_WIDTH-1:0]           result,
    output logic                                     clip
);
    import iir_df1_pkg::*;

    localparam int LO_W   = (ACC_WIDTH + 1) / 2;
    localparam int HI_W   = ACC_WIDTH - LO_W;
    localparam int MA_W   = LO_W + 1;
    localparam int MP_W   = MA_W + COEF_WIDTH;
    localparam int SUM_W  = 2 * LO_W + COEF_WIDTH + 1;
    localparam int RSH    = 2 * COEF_FRAC;
    localparam int YW     = SUM_W - RSH;
    localparam int TOP_W  = YW - SAMPLE_WIDTH + 1;

    logic signed [MA_W-1:0]         mul_a;
    logic signed [MP_W-1:0]         mul_p;
    logic signed [MP_W-1:0]         lo_reg;
    logic signed [MP_W-1:0]         hi_reg;
    logic signed [SUM_W-1:0]        sum;
    logic signed [YW-1:0]           yw;
    logic [TOP_W-1:0]               top_bits;
    logic signed [SUM_W-1:0]        half;

    always_comb
    begin
        if (ctl.mul_hi)
        begin
            mul_a = {{(MA_W-HI_W){acc[ACC_WIDTH-1]}}, acc[ACC_WIDTH-1:LO_W]};
        end
        else
        begin
            mul_a = {1'b0, acc[LO_W-1:0]};
        end
    end

    assign mul_p = mul_a * recip;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_lo)
        begin
            lo_reg <= mul_p;
        end
        if (ctl.mul_hi)
        begin
            hi_reg <= mul_p;
        end
    end

    assign half = SUM_W'(1) <<< (RSH - 1);

    always_comb
    begin
        sum = ({{(SUM_W-MP_W){hi_reg[MP_W-1]}}, hi_reg} <<< LO_W)
            + {{(SUM_W-MP_W){lo_reg[MP_W-1]}}, lo_reg}
            + half;
        yw       = sum[SUM_W-1:RSH];
        top_bits = yw[YW-1:SAMPLE_WIDTH-1];
        if ((top_bits == '0) || (top_bits == '1))
        begin
            result = yw[SAMPLE_WIDTH-1:0];
            clip   = 1'b0;
        end
        else if (yw[YW-1])
        begin
            result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            clip   = 1'b1;
        end
        else
        begin
            result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            clip   = 1'b1;
        end
    end

endmodule

[src/iir_direct_form_one_filter.sv]
`timescale 1ns / 1ps
// top level of the direct-form-I iir filter
//
// in_ch carries one signed sample per beat, out_ch one filtered sample and a
// clip flag per beat; both are valid/ready channels. Coefficients are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// sample is in flight, and the block itself does not enforce it. Indices 0..ORDER
// take the numerator oldest first, then ORDER denominator terms oldest first,
// then the reciprocal of the leading denominator term. Other indices are ignored.
// A ring of 2*ORDER+1 cells holds coefficients and history and turns once per
// sample past one shared multiplier, then a split multiply scales the sum.
// A new input beat is taken only once the previous sample is through its ring
// pass of the single multiplier, a drain step and the two scaling products.
// The output register holds a finished sample while the receiver stalls, and
// the next input beat is already taken; the following sample waits in its
// last step until the register frees.
// Reset clears the history, sets the newest numerator term and the reciprocal
// to one and all other coefficients to zero.
module iir_direct_form_one_filter #(
    parameter int ORDER        = 2,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    iir_df1_in_if.sink                                       in_ch,
    iir_df1_out_if.source                                    out_ch,
    input  logic                                             cfg_we,
    input  logic [$clog2(2*ORDER+2)-1:0]                     cfg_index,
    input  logic [iir_df1_pkg::COEF_WIDTH-1:0]               cfg_data
);
    import iir_df1_pkg::*;

    localparam int N      = 2 * ORDER + 1;
    localparam int IDX_W  = $clog2(2 * ORDER + 2);
    localparam int STEP_W = $clog2(N);
    localparam int MP_W   = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = MP_W + $clog2(N);

    state_t state_reg;
    state_t state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    cell_ctl_t                      ctl [N];
    logic signed [COEF_WIDTH-1:0]   coefs [N];
    logic signed [SAMPLE_WIDTH-1:0] samples [N];

    logic signed [COEF_WIDTH-1:0]   lead_reg;
    logic signed [MP_W-1:0]         prod_reg;
    logic                           prod_valid_reg;
    logic                           neg_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [ACC_W-1:0]        prod_ext;

    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                           clipped_reg;

    scale_ctl_t                     sctl;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic                           y_clip;

    logic out_free;
    logic in_acc;
    logic finish;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign finish    = (state_reg == S_DONE) && out_free;
    assign in_ch.ready = (state_reg == S_IDLE) || finish;
    assign in_acc    = in_ch.valid && in_ch.ready;

    // ring of cells, cell 0 feeds the multiplier
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        localparam int NB = (k + 1) % N;
        logic signed [SAMPLE_WIDTH-1:0] new_s;

        always_comb
        begin
            ctl[k].load   = cfg_we && (cfg_index == IDX_W'(k));
            ctl[k].rotate = (state_reg == S_MAC);
            if (k <= ORDER)
            begin
                ctl[k].shift = in_acc;
            end
            else
            begin
                ctl[k].shift = finish;
            end
            if (k == ORDER)
            begin
                new_s = in_ch.sample_in;
            end
            else if (k == 2 * ORDER)
            begin
                new_s = y;
            end
            else
            begin
                new_s = samples[NB];
            end
        end

        iir_df1_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COEF_RESET   ((k == ORDER) ? COEF_ONE : '0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[k]),
            .cfg_coef   (cfg_data),
            .nb_coef    (coefs[NB]),
            .nb_sample  (samples[NB]),
            .new_sample (new_s),
            .coef       (coefs[k]),
            .sample     (samples[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= COEF_ONE;
        end
        else if (cfg_we && (cfg_index == IDX_W'(2 * ORDER + 1)))
        begin
            lead_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_MAC;
                    step_next  = '0;
                end
            end
            S_MAC:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(N - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_LO;
            end
            S_LO:
            begin
                state_next = S_HI;
            end
            S_HI:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (in_acc)
                begin
                    state_next = S_MAC;
                    step_next  = '0;
                end
                else if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            prod_valid_reg <= (state_reg == S_MAC);
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // shared multiply-accumulate, one product behind the ring
    assign prod_ext = {{(ACC_W-MP_W){prod_reg[MP_W-1]}}, prod_reg};

    always_comb
    begin
        acc_next = acc_reg;
        if (in_acc)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            if (neg_reg)
            begin
                acc_next = acc_reg - prod_ext;
            end
            else
            begin
                acc_next = acc_reg + prod_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= samples[0] * coefs[0];
        neg_reg  <= (step_reg > STEP_W'(ORDER));
        acc_reg  <= acc_next;
        if (finish)
        begin
            sample_out_reg <= y;
            clipped_reg    <= y_clip;
        end
    end

    assign sctl.mul_lo = (state_reg == S_LO);
    assign sctl.mul_hi = (state_reg == S_HI);

    iir_df1_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_W)
    ) u_scale (
        .clk    (clk),
        .ctl    (sctl),
        .acc    (acc_reg),
        .recip  (lead_reg),
        .result (y),
        .clip   (y_clip)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = sample_out_reg;
    assign out_ch.clipped    = clipped_reg;

endmodule
